@@ hw/rtl/olt_pkg.sv @@
// Package for the ordered list table: sizes, operation and status codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package olt_pkg;

   localparam int DEPTH       = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int COUNT_W     = $clog2(DEPTH + 1);

   localparam logic [2:0] OP_APPEND       = 3'd0;
   localparam logic [2:0] OP_REMOVE_VALUE = 3'd1;
   localparam logic [2:0] OP_REMOVE_LAST  = 3'd2;
   localparam logic [2:0] OP_GET_LAST     = 3'd3;
   localparam logic [2:0] OP_INDEX_OF     = 3'd4;
   localparam logic [2:0] OP_COUNT        = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic       load_req;
      logic       append;
      logic       dec_count;
      logic       scan_issue;
      logic       scan_check;
      logic       last_issue;
      logic       shift_start;
      logic       shift_write;
      logic       finish;
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       count_zero;
      logic       count_full;
      logic       scan_more;
      logic       chk_vld;
      logic       hit;
   } stat_type;

endpackage

@@ hw/rtl/olt_ram.sv @@
// Single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module olt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/olt_datapath.sv @@
// Datapath of the ordered list table: entry store, fill count, scan and shift
// pointers, match counter and result registers.
// Depends on olt_pkg and olt_ram.
module olt_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         req_operation,
   input  logic [31:0]        req_item_value,
   input  olt_pkg::cmd_type   cmd,
   output olt_pkg::stat_type  stat,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [5:0]         rsp_position,
   output logic [6:0]         rsp_match_count,
   output logic [31:0]        rsp_last_value,
   output logic [6:0]         rsp_fill_level
);

   logic [olt_pkg::COUNT_W-1:0]     count_ff, count_in, count_less;
   logic [2:0]                      op_ff;
   logic [olt_pkg::VALUE_WIDTH-1:0] value_ff;
   logic [olt_pkg::COUNT_W-1:0]     rd_idx_ff;
   logic [olt_pkg::ADDR_W-1:0]      chk_idx_ff;
   logic                            chk_vld_ff;
   logic [olt_pkg::ADDR_W-1:0]      wr_idx_ff;
   logic [olt_pkg::COUNT_W-1:0]     match_cnt_ff;
   logic                            hit;

   logic                            ram_wr_en;
   logic [olt_pkg::ADDR_W-1:0]      ram_wr_addr, ram_rd_addr;
   logic [olt_pkg::VALUE_WIDTH-1:0] ram_wr_data, ram_rd_data;

   logic                            rsp_strobe_ff;
   logic [1:0]                      rsp_status_ff;
   logic [5:0]                      rsp_position_ff;
   logic [6:0]                      rsp_match_count_ff;
   logic [31:0]                     rsp_last_value_ff;
   logic [6:0]                      rsp_fill_level_ff;

   assign count_less = count_ff - olt_pkg::COUNT_W'(1);
   assign hit        = chk_vld_ff && (ram_rd_data == value_ff);

   always_comb begin
      count_in = count_ff;
      if (cmd.append) begin
         count_in = count_ff + olt_pkg::COUNT_W'(1);
      end else if (cmd.dec_count) begin
         count_in = count_less;
      end
   end

   assign ram_wr_en   = cmd.append || cmd.shift_write;
   assign ram_wr_addr = cmd.append ? count_ff[olt_pkg::ADDR_W-1:0] : wr_idx_ff;
   assign ram_wr_data = cmd.append ? value_ff : ram_rd_data;
   assign ram_rd_addr = cmd.last_issue ? count_less[olt_pkg::ADDR_W-1:0]
                                       : rd_idx_ff[olt_pkg::ADDR_W-1:0];

   olt_ram #(
      .WIDTH (olt_pkg::VALUE_WIDTH),
      .DEPTH (olt_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         chk_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         chk_vld_ff    <= cmd.scan_issue;
         rsp_strobe_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff        <= req_operation;
         value_ff     <= olt_pkg::VALUE_WIDTH'(req_item_value);
         rd_idx_ff    <= '0;
         match_cnt_ff <= '0;
      end
      if (cmd.scan_issue) begin
         rd_idx_ff  <= rd_idx_ff + olt_pkg::COUNT_W'(1);
         chk_idx_ff <= rd_idx_ff[olt_pkg::ADDR_W-1:0];
      end
      if (cmd.scan_check && hit) begin
         match_cnt_ff <= match_cnt_ff + olt_pkg::COUNT_W'(1);
      end
      if (cmd.shift_start) begin
         rd_idx_ff <= olt_pkg::COUNT_W'(chk_idx_ff) + olt_pkg::COUNT_W'(1);
         wr_idx_ff <= chk_idx_ff;
      end
      if (cmd.shift_write) begin
         wr_idx_ff <= wr_idx_ff + olt_pkg::ADDR_W'(1);
      end
      if (cmd.finish) begin
         rsp_status_ff      <= cmd.status;
         rsp_position_ff    <= (op_ff == olt_pkg::OP_INDEX_OF && cmd.status == olt_pkg::ST_OK)
                               ? 6'(chk_idx_ff) : 6'd0;
         rsp_match_count_ff <= (op_ff == olt_pkg::OP_COUNT) ? 7'(match_cnt_ff) : 7'd0;
         rsp_last_value_ff  <= (op_ff == olt_pkg::OP_GET_LAST && cmd.status == olt_pkg::ST_OK)
                               ? 32'(ram_rd_data) : 32'd0;
         rsp_fill_level_ff  <= 7'(count_in);
      end
   end

   assign stat.op         = op_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.count_full = (count_ff == olt_pkg::COUNT_W'(olt_pkg::DEPTH));
   assign stat.scan_more  = (rd_idx_ff < count_ff);
   assign stat.chk_vld    = chk_vld_ff;
   assign stat.hit        = hit;

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_match_count = rsp_match_count_ff;
   assign rsp_last_value  = rsp_last_value_ff;
   assign rsp_fill_level  = rsp_fill_level_ff;

endmodule

@@ hw/rtl/olt_ctrl.sv @@
// Controller of the ordered list table: sequences dispatch, scan, shift and
// reply, driving the datapath by commands. Depends on olt_pkg.
module olt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  olt_pkg::stat_type  stat,
   output olt_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_SHIFT,
      S_REPLY
   } state_type;

   state_type state_ff, state_in;
   logic      stop_on_hit;

   assign stop_on_hit = (stat.op != olt_pkg::OP_COUNT);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.op)
               olt_pkg::OP_APPEND: begin
                  cmd.append = !stat.count_full;
                  cmd.status = stat.count_full ? olt_pkg::ST_FULL : olt_pkg::ST_OK;
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
               olt_pkg::OP_REMOVE_LAST: begin
                  cmd.dec_count = !stat.count_zero;
                  cmd.status    = stat.count_zero ? olt_pkg::ST_EMPTY : olt_pkg::ST_OK;
                  cmd.finish    = 1'b1;
                  state_in      = S_IDLE;
               end
               olt_pkg::OP_GET_LAST: begin
                  if (stat.count_zero) begin
                     cmd.status = olt_pkg::ST_EMPTY;
                     cmd.finish = 1'b1;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.last_issue = 1'b1;
                     state_in       = S_REPLY;
                  end
               end
               olt_pkg::OP_REMOVE_VALUE, olt_pkg::OP_INDEX_OF, olt_pkg::OP_COUNT: begin
                  state_in = S_SCAN;
               end
               default: begin
                  cmd.status = olt_pkg::ST_OK;
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan_check = 1'b1;
            cmd.scan_issue = stat.scan_more && !(stat.hit && stop_on_hit);
            if (stat.hit && stat.op == olt_pkg::OP_INDEX_OF) begin
               cmd.status = olt_pkg::ST_OK;
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else if (stat.hit && stat.op == olt_pkg::OP_REMOVE_VALUE) begin
               cmd.shift_start = 1'b1;
               state_in        = S_SHIFT;
            end else if (!stat.scan_more && !stat.chk_vld) begin
               cmd.status = stop_on_hit ? olt_pkg::ST_NOT_FOUND : olt_pkg::ST_OK;
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_SHIFT: begin
            cmd.scan_issue  = stat.scan_more;
            cmd.shift_write = stat.chk_vld;
            if (!stat.scan_more && !stat.chk_vld) begin
               cmd.dec_count = 1'b1;
               cmd.status    = olt_pkg::ST_OK;
               cmd.finish    = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_REPLY: begin
            cmd.status = olt_pkg::ST_OK;
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ hw/rtl/ordered_list_table.sv @@
// Ordered list table: an ordered list of up to DEPTH values with append,
// remove, read-last, search and count requests, one result per request.
// Depends on olt_pkg, olt_ctrl and olt_datapath.
//
// Usage:
//   A request (req_operation, req_item_value) is taken at a rising edge with
//   start high and busy low. Its result appears on the rsp_ ports for one
//   cycle, marked by rsp_strobe; the receiver cannot stall and must take it.
//   Steps from the accepting edge to the strobe, by operation:
//     append, remove last, unused codes, empty get last : dispatch only
//     get last                                          : dispatch, read of last entry
//     index of (match at position p)                    : scan up to p
//     index of or remove value without match, count     : scan of all entries
//     remove value (match at p)                         : scan up to p, then
//                                                         shift of the entries after p
//   The scan and the gap-closing shift walk the store through its single
//   read port, one entry per cycle, and the shift carries on from where the
//   scan stopped. busy falls as the strobe rises, so a new request can be
//   taken in the strobe cycle.
//   Reset empties the list at once; store contents are left as they are.
module ordered_list_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_item_value,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_position,
   output logic [6:0]  rsp_match_count,
   output logic [31:0] rsp_last_value,
   output logic [6:0]  rsp_fill_level
);

   olt_pkg::cmd_type  cmd;
   olt_pkg::stat_type stat;

   olt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   olt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_operation   (req_operation),
      .req_item_value  (req_item_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_match_count (rsp_match_count),
      .rsp_last_value  (rsp_last_value),
      .rsp_fill_level  (rsp_fill_level)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without controller leaving idle");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_full_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == olt_pkg::ST_FULL) |->
      (rsp_fill_level == 7'(olt_pkg::DEPTH)))
      else $error("full status with list not at capacity");

   a_empty_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == olt_pkg::ST_EMPTY) |->
      (rsp_fill_level == 7'd0 && rsp_last_value == 32'd0))
      else $error("empty status with entries present or nonzero value");

endmodule
